// File: design/lr_pkg.sv
`timescale 1ns / 1ps
package lr_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int MAX_PIXELS = 64;
	localparam int COORD_W    = 6;
	localparam int SIDE_W     = 7;
	localparam int CNT_W      = $clog2(MAX_PIXELS);
	localparam int PC_W       = 2;

	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} lr_seg_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic               last_pixel;
	} lr_pix_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_IDLE,
		COND_DONE,
		COND_ALWAYS
	} lr_cond_t;

	// datapath controls decoded from one microcode word
	typedef struct packed {
		logic load;
		logic emit;
		logic calc;
		logic move;
	} lr_ctrl_t;

	typedef struct packed {
		logic done;
	} lr_stat_t;

	typedef struct packed {
		lr_ctrl_t          ctrl;
		lr_cond_t          cond;
		logic [PC_W-1:0]   target;
	} lr_uword_t;

	localparam logic [PC_W-1:0] STEP_WAIT = 2'd0;
	localparam logic [PC_W-1:0] STEP_EMIT = 2'd1;
	localparam logic [PC_W-1:0] STEP_CALC = 2'd2;
	localparam logic [PC_W-1:0] STEP_MOVE = 2'd3;

	// microprogram rom
	function automatic lr_uword_t lr_ucode(input logic [PC_W-1:0] pc);
		lr_uword_t w;
		w = '0;
		case (pc)
			STEP_WAIT: begin
				w.ctrl.load = 1'b1;
				w.cond      = COND_IDLE;
				w.target    = STEP_WAIT;
			end
			STEP_EMIT: begin
				w.ctrl.emit = 1'b1;
				w.cond      = COND_DONE;
				w.target    = STEP_WAIT;
			end
			STEP_CALC: begin
				w.ctrl.calc = 1'b1;
				w.cond      = COND_NONE;
				w.target    = STEP_WAIT;
			end
			STEP_MOVE: begin
				w.ctrl.move = 1'b1;
				w.cond      = COND_ALWAYS;
				w.target    = STEP_EMIT;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

// File: design/lr_cfg.sv
`timescale 1ns / 1ps
module lr_cfg
	import lr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output logic [SIDE_W-1:0]   side
);

	logic [SIDE_W-1:0] grid_side_q;
	logic              hit;

	assign hit    = (paddr[2] == 1'b0);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_RESET;
		end else if (psel && penable && pwrite && hit) begin
			grid_side_q <= pwdata[SIDE_W-1:0];
		end
	end

	assign prdata = hit ? {{(32-SIDE_W){1'b0}}, grid_side_q} : 32'd0;

	// zero acts as one, anything above the grid max saturates
	always_comb begin
		if (grid_side_q == '0) begin
			side = SIDE_W'(1);
		end else if (grid_side_q > SIDE_W'(MAX_SIDE)) begin
			side = SIDE_W'(MAX_SIDE);
		end else begin
			side = grid_side_q;
		end
	end

endmodule

// File: design/lr_seq.sv
`timescale 1ns / 1ps
module lr_seq
	import lr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  lr_stat_t stat,
	output lr_ctrl_t ctrl,
	output logic     busy
);

	logic [PC_W-1:0] pc_q;
	lr_uword_t       uw;
	logic            take;

	assign uw   = lr_ucode(pc_q);
	assign busy = (pc_q != STEP_WAIT);

	always_comb begin
		case (uw.cond)
			COND_NONE:   take = 1'b0;
			COND_IDLE:   take = !start;
			COND_DONE:   take = stat.done;
			COND_ALWAYS: take = 1'b1;
			default:     take = 1'b0;
		endcase
	end

	always_comb begin
		ctrl      = uw.ctrl;
		ctrl.load = uw.ctrl.load & start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

// File: design/lr_dp.sv
`timescale 1ns / 1ps
module lr_dp
	import lr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  lr_ctrl_t          ctrl,
	input  lr_seg_t           seg,
	input  logic [SIDE_W-1:0] side,
	output lr_stat_t          stat,
	output lr_pix_t           pix,
	output logic              pix_valid
);

	// walk coordinates carry a guard bit and a sign
	logic signed [7:0]          walk_x_q, walk_y_q;
	logic [COORD_W-1:0]         goal_x_q, goal_y_q;
	logic signed [7:0]          span_x_q, span_y_q;
	logic                       step_x_negative_q, step_y_negative_q;
	logic [CNT_W-1:0]           count_q;
	logic signed [15:0]         pa_q, pb_q, pc_q, pd_q;
	lr_pix_t                    pix_q;
	logic                       valid_q;

	logic signed [15:0] ix, iy, rx, ry, dx16, dy16;
	logic signed [15:0] e1, e2, e3, d1, d2, d3;
	logic signed [7:0]  ix8, iy8, nx, ny;
	logic signed [7:0]  dx_in, dy_in;
	logic               at_goal, done;
	logic [COORD_W-1:0] cx, cy;

	assign dx_in = $signed({2'b00, seg.end_x}) - $signed({2'b00, seg.start_x});
	assign dy_in = $signed({2'b00, seg.end_y}) - $signed({2'b00, seg.start_y});

	assign ix8 = step_x_negative_q ? -8'sd1 : 8'sd1;
	assign iy8 = step_y_negative_q ? -8'sd1 : 8'sd1;
	assign ix  = 16'(ix8);
	assign iy  = 16'(iy8);
	assign dx16 = 16'(span_x_q);
	assign dy16 = 16'(span_y_q);
	assign rx = $signed({10'd0, goal_x_q}) - 16'(walk_x_q);
	assign ry = $signed({10'd0, goal_y_q}) - 16'(walk_y_q);

	assign at_goal = (walk_x_q == $signed({2'b00, goal_x_q}))
		&& (walk_y_q == $signed({2'b00, goal_y_q}));
	assign done = at_goal || (count_q == CNT_W'(MAX_PIXELS - 1));
	assign stat.done = done;

	function automatic logic [COORD_W-1:0] clamp(input logic signed [7:0] v,
		input logic [SIDE_W-1:0] s);
		logic [COORD_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if ({1'b0, v[6:0]} >= {1'b0, s}) begin
			r = COORD_W'(s - SIDE_W'(1));
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	assign cx = clamp(walk_x_q, side);
	assign cy = clamp(walk_y_q, side);

	// absolute cross-product errors for x, y and diagonal moves
	assign d1 = pa_q - pb_q;
	assign d2 = pc_q - pd_q;
	assign d3 = pa_q - pd_q;
	assign e1 = (d1 < 0) ? -d1 : d1;
	assign e2 = (d2 < 0) ? -d2 : d2;
	assign e3 = (d3 < 0) ? -d3 : d3;

	always_comb begin
		nx = walk_x_q;
		ny = walk_y_q;
		if (e1 < e2) begin
			nx = walk_x_q + ix8;
			if (e3 <= e1) ny = walk_y_q + iy8;
		end else begin
			ny = walk_y_q + iy8;
			if (e3 <= e2) nx = walk_x_q + ix8;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			walk_x_q          <= $signed({2'b00, seg.start_x});
			walk_y_q          <= $signed({2'b00, seg.start_y});
			goal_x_q          <= seg.end_x;
			goal_y_q          <= seg.end_y;
			span_x_q          <= dx_in;
			span_y_q          <= dy_in;
			step_x_negative_q <= dx_in < 0;
			step_y_negative_q <= dy_in < 0;
			count_q           <= '0;
		end
		if (ctrl.emit) begin
			count_q           <= count_q + CNT_W'(1);
			pix_q.pixel_x     <= cx;
			pix_q.pixel_y     <= cy;
			pix_q.last_pixel  <= done;
		end
		if (ctrl.calc) begin
			pa_q <= 16'(dy16 * (rx - ix));
			pb_q <= 16'(dx16 * ry);
			pc_q <= 16'(dy16 * rx);
			pd_q <= 16'(dx16 * (ry - iy));
		end
		if (ctrl.move) begin
			walk_x_q <= nx;
			walk_y_q <= ny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctrl.emit;
		end
	end

	assign pix       = pix_q;
	assign pix_valid = valid_q;

endmodule

// File: design/line_rasterizer.sv
`timescale 1ns / 1ps
// channel   direction  handshake                     payload
// segment   in         start && !busy                seg (lr_seg_t)
// pixel     out        pix_valid, one cycle          pix (lr_pix_t)
// config    in         apb write, psel&penable&pwrite  grid_side at byte 0
//
// each pixel but the last takes three microcode steps (emit, multiply, move),
// the last only its emit; busy stays high until the last emit of a segment
// (at most 64 pixels), then the wait step takes the next request
// the pixel appears on pix in the cycle after its emit step; a new segment can
// start while the last pixel of the previous one is still showing
// reset clears the step counter and the output strobe, grid_side resets to 64
// results cannot be stalled
module line_rasterizer
	import lr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  lr_seg_t     seg,
	output lr_pix_t     pix,
	output logic        pix_valid,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lr_ctrl_t          ctrl;
	lr_stat_t          stat;
	logic [SIDE_W-1:0] side;

	lr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.side    (side)
	);

	lr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	lr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.seg       (seg),
		.side      (side),
		.stat      (stat),
		.pix       (pix),
		.pix_valid (pix_valid)
	);

endmodule
